FILE: rtl/core/mavg_pkg.sv
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared types and constants of the two-mode moving average.
// ----------------------------------------------------------------------------
`default_nettype none

package mavg_pkg;

  localparam int WL_W       = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 7;
  localparam int MEAN_W     = 32;
  localparam int FRAC_BITS  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_MODE     = 4'd1;

  localparam logic [WL_W-1:0] WL_RESET   = 7'd8;
  localparam logic            MODE_RESET = 1'b0;

  localparam logic MODE_PLAIN    = 1'b0;
  localparam logic MODE_WEIGHTED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_DIV,
    ST_HOLD
  } mavg_state_e;

  typedef struct packed {
    logic clr;
    logic vld;
    logic live;
    logic last;
  } mac_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/mavg_mem.sv
// ----------------------------------------------------------------------------
// mavg_mem
// Sample window storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 24,
  parameter int AW    = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/mavg_mac.sv
// ----------------------------------------------------------------------------
// mavg_mac
// Shared multiply-accumulate unit: one weighted window entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_mac
  import mavg_pkg::*;
#(
  parameter int SAMPLE_BITS = 24,
  parameter int LW          = 7,
  parameter int ACC_W       = 40
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mac_req_t                      req_i,
  input  wire logic signed [SAMPLE_BITS-1:0] data_i,
  input  wire logic        [LW-1:0]          wt_i,
  output logic signed      [ACC_W-1:0]       acc_o,
  output logic                               done_o
);

  localparam int PW = SAMPLE_BITS + LW + 1;

  logic signed [PW-1:0]    prod_d;
  logic signed [PW-1:0]    prod_q;
  logic                    p_vld_q;
  logic                    p_last_q;
  logic                    p_clr_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    done_q;

  assign prod_d = req_i.live ? (PW'(data_i) * PW'($signed({1'b0, wt_i}))) : '0;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q  <= 1'b0;
      p_last_q <= 1'b0;
      p_clr_q  <= 1'b0;
      done_q   <= 1'b0;
      acc_q    <= '0;
    end else begin
      p_vld_q  <= req_i.vld;
      p_last_q <= req_i.vld & req_i.last;
      p_clr_q  <= req_i.clr;
      done_q   <= p_vld_q & p_last_q;
      if (p_clr_q) begin
        acc_q <= '0;
      end else if (p_vld_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: rtl/core/mavg_div.sv
// ----------------------------------------------------------------------------
// mavg_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_div #(
  parameter int DVD_W = 48,
  parameter int DVS_W = 14
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic      [DVD_W-1:0] quo_o,
  output logic                  done_o
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CW'(DVD_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: rtl/core/moving_average_two_mode_top.sv
// ----------------------------------------------------------------------------
// moving_average_two_mode_top
// Plain or linearly weighted moving average over a ring window, Q8 result.
// ----------------------------------------------------------------------------
// From acceptance to result, a request walks the effective window of N
// entries (N the effective window length), drains the multiply-accumulate
// pipeline, runs the serial divider at one quotient bit per cycle plus its
// start and finish, and loads the output register.
// The walk over the window reads one entry per cycle through the single read
// port of the window memory into one shared multiply-accumulate unit. The
// block accepts the next request once the previous result sits in the output
// register. Unwritten entries read as zero through a fill count, so there
// is no clearing pass after reset or after a register write.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_two_mode_top
  import mavg_pkg::*;
#(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic        [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic        [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed      [MEAN_W-1:0]      out_mean_q8_o
);

  localparam int LW    = $clog2(MAX_WINDOW + 1);
  localparam int LW1   = LW + 1;
  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int NW    = (LW > WL_W) ? LW : WL_W;
  localparam int ACC_R = SAMPLE_BITS + 2 * LW + 1;
  localparam int ACC_W = (ACC_R > MEAN_W) ? ACC_R : MEAN_W;
  localparam int QW    = ACC_W + FRAC_BITS;
  localparam int DVS_W = 2 * LW;

  mavg_state_e state_q, state_d;

  logic [WL_W-1:0]  wl_q;
  logic             mode_q;
  logic [AW-1:0]    pos_q;
  logic [AW-1:0]    pos_d;
  logic [LW-1:0]    fill_q;
  logic [AW-1:0]    idx_q;
  logic [AW-1:0]    idx_d;
  logic [LW-1:0]    cnt_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] dvs_d;
  logic [LW-1:0]    n_eff;
  logic [NW-1:0]    wl_ext;
  logic [DVS_W-1:0] n_wide;
  logic             accept;
  logic             cfg_hit;
  logic             out_free;

  mac_req_t         issue;
  mac_req_t         req_q;
  logic [LW-1:0]    issue_wt;
  logic [LW-1:0]    wt_q;

  logic [SAMPLE_BITS-1:0] rd_data;
  logic signed [ACC_W-1:0] acc;
  logic                    mac_done;

  logic             neg;
  logic [ACC_W-1:0] mag;
  logic [QW-1:0]    quo;
  logic             div_done;
  logic             div_start;
  logic             neg_q;
  logic [MEAN_W-1:0] q32;
  logic [MEAN_W-1:0] mean_d;
  logic              sat_pos;
  logic              sat_neg;
  logic              out_valid_q;
  logic [MEAN_W-1:0] out_mean_q;

  // Effective window length: zero acts as one, clamp to the window size.
  always_comb begin
    wl_ext = NW'(wl_q);
    if (wl_ext == '0) begin
      n_eff = LW'(1);
    end else if (wl_ext > NW'(MAX_WINDOW)) begin
      n_eff = LW'(MAX_WINDOW);
    end else begin
      n_eff = LW'(wl_ext);
    end
  end

  assign n_wide = DVS_W'(n_eff);
  assign dvs_d  = (mode_q == MODE_WEIGHTED) ?
                  DVS_W'((n_wide * (n_wide + DVS_W'(1))) >> 1) : n_wide;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign cfg_hit  = cfg_we_i &&
                    ((cfg_idx_i == CFG_WINDOW_LENGTH) || (cfg_idx_i == CFG_MEAN_MODE));

  assign pos_d = (LW1'(pos_q) + LW1'(1) == LW1'(n_eff)) ? '0 : pos_q + AW'(1);
  assign idx_d = (LW1'(idx_q) + LW1'(1) == LW1'(n_eff)) ? '0 : idx_q + AW'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_READ;
      ST_READ: if (cnt_q == n_eff) state_d = ST_WAIT;
      ST_WAIT: if (mac_done) state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_HOLD;
      ST_HOLD: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    issue      = '0;
    issue_wt   = LW'(1);
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        issue.clr  = in_valid_i;
      end
      ST_READ: begin
        issue.vld  = 1'b1;
        issue.live = LW1'(idx_q) < LW1'(fill_q);
        issue.last = cnt_q == n_eff;
        issue_wt   = (mode_q == MODE_WEIGHTED) ? cnt_q : LW'(1);
      end
      ST_WAIT: div_start = mac_done;
      ST_DIV:  ;
      ST_HOLD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wl_q    <= WL_RESET;
      mode_q  <= MODE_RESET;
      pos_q   <= '0;
      fill_q  <= '0;
      req_q   <= '0;
    end else begin
      state_q <= state_d;
      req_q   <= issue;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WINDOW_LENGTH: wl_q   <= cfg_data_i[WL_W-1:0];
          CFG_MEAN_MODE:     mode_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        pos_q  <= '0;
        fill_q <= '0;
      end else if (accept) begin
        pos_q  <= pos_d;
        fill_q <= (fill_q == n_eff) ? fill_q : fill_q + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wt_q <= issue_wt;
    if (accept) begin
      idx_q <= pos_d;
      cnt_q <= LW'(1);
      dvs_q <= dvs_d;
    end else if (state_q == ST_READ) begin
      idx_q <= idx_d;
      cnt_q <= cnt_q + LW'(1);
    end
  end

  mavg_mem #(
    .DEPTH (MAX_WINDOW),
    .WIDTH (SAMPLE_BITS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (pos_q),
    .wdata_i (in_sample_i),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  mavg_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .LW          (LW),
    .ACC_W       (ACC_W)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_q),
    .data_i ($signed(rd_data)),
    .wt_i   (wt_q),
    .acc_o  (acc),
    .done_o (mac_done)
  );

  assign neg = acc[ACC_W-1];
  assign mag = neg ? (~acc + ACC_W'(1)) : acc;

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      neg_q <= neg;
    end
  end

  mavg_div #(
    .DVD_W (QW),
    .DVS_W (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({mag, FRAC_BITS'(0)}),
    .divisor_i  (dvs_q),
    .quo_o      (quo),
    .done_o     (div_done)
  );

  // Saturate to the signed 32-bit range.
  assign q32     = quo[MEAN_W-1:0];
  assign sat_pos = |quo[QW-1:MEAN_W-1];
  assign sat_neg = (|quo[QW-1:MEAN_W]) || (quo[MEAN_W-1] && (|quo[MEAN_W-2:0]));

  always_comb begin
    if (neg_q) begin
      mean_d = sat_neg ? {1'b1, {(MEAN_W-1){1'b0}}} : (~q32 + MEAN_W'(1));
    end else begin
      mean_d = sat_pos ? {1'b0, {(MEAN_W-1){1'b1}}} : q32;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_HOLD && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_HOLD && out_free) begin
      out_mean_q <= mean_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_mean_q8_o = $signed(out_mean_q);

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= n_eff)
    else $error("fill count exceeds window length");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW1'(pos_q) < LW1'(n_eff))
    else $error("write position outside window");

  a_mac_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> state_q == ST_WAIT)
    else $error("accumulation finished outside wait state");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("division finished outside divide state");

endmodule

`default_nettype wire

FILE: test/moving_average_two_mode_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// moving_average_two_mode_top_tb
// Self-checking bench for the plain and weighted ring-window moving average.
// A predictor keeps its own window and register copy, computes the Q8 mean for
// every accepted sample and compares each result in order. Directed samples
// hit the field extremes and register corner values (window length 0, above
// the maximum, writes to unmapped indexes); random phases then vary window
// length and mode with random idling on both channels.
// ----------------------------------------------------------------------------

import mavg_pkg::*;

class window_mean_board;
  localparam int MAX_WIN  = 64;
  localparam int SMP_BITS = 24;

  logic        [WL_W-1:0]     length_reg;
  logic                       mode_reg;
  logic signed [SMP_BITS-1:0] ring[MAX_WIN];
  int unsigned                wr_pos;
  logic signed [MEAN_W-1:0]   pending_means[$];
  int                         errors;
  int                         checked;

  function new();
    length_reg = WL_RESET;
    mode_reg   = MODE_RESET;
    errors     = 0;
    checked    = 0;
    clear_ring();
  endfunction

  function void clear_ring();
    foreach (ring[i]) ring[i] = '0;
    wr_pos = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_WINDOW_LENGTH) begin
      length_reg = data[WL_W-1:0];
      clear_ring();
    end else if (idx == CFG_MEAN_MODE) begin
      mode_reg = data[0];
      clear_ring();
    end
  endfunction

  function int unsigned span();
    if (length_reg < 1) return 1;
    if (length_reg > MAX_WIN) return MAX_WIN;
    return 32'(length_reg);
  endfunction

  function void note_sample(logic signed [SMP_BITS-1:0] s);
    int unsigned n;
    int unsigned pos;
    int unsigned idx;
    longint      acc;
    longint      div;
    longint      q;
    n   = span();
    pos = wr_pos;
    acc = 0;
    if (pos >= n) pos = 0;
    ring[pos] = s;
    pos = (pos + 1 == n) ? 0 : pos + 1;
    wr_pos = pos;
    if (mode_reg == MODE_PLAIN) begin
      for (int j = 0; j < n; j++) acc += longint'(ring[j]);
      div = longint'(n);
    end else begin
      idx = pos;
      for (int j = 1; j <= n; j++) begin
        acc += longint'(ring[idx]) * longint'(j);
        idx = (idx + 1 == n) ? 0 : idx + 1;
      end
      div = longint'(n) * longint'(n + 1) / 2;
    end
    q = (acc * 256) / div;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    pending_means.insert(pending_means.size(), q[MEAN_W-1:0]);
  endfunction

  function void check_mean(logic signed [MEAN_W-1:0] got);
    logic signed [MEAN_W-1:0] want;
    checked++;
    if (pending_means.size() == 0) begin
      $error("mean_q8: no result expected, actual %0d", got);
      errors++;
      return;
    end
    want = pending_means.pop_front();
    if (got !== want) begin
      $error("mean_q8 mismatch: expected %0d, actual %0d", want, got);
      errors++;
    end
  endfunction

  function int pending();
    return pending_means.size();
  endfunction
endclass

module moving_average_two_mode_top_tb;
  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_BITS  = 24;
  localparam int ITEMS        = 1950;
  localparam int IDLE_PCT     = 21;
  localparam int CALM_FROM    = 700;
  localparam int CALM_TO      = 1000;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 2 * (MAX_WINDOW + 61);

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FREE = CFG_MEAN_MODE + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP  = '1;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX  = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN  = 24'sh800000;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_ZERO = 24'sh000000;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_NEG1 = 24'shFFFFFF;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic        [CFG_IDX_W-1:0]   cfg_idx_i;
  logic        [CFG_DATA_W-1:0]  cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] in_sample_i;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [MEAN_W-1:0]      out_mean_q8_o;

  window_mean_board means;
  bit               calm;
  int               sent;
  int               reg_writes;
  int               phases;
  int               idle_cycles = 0;

  moving_average_two_mode_top #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_sample_i  (in_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_mean_q8_o(out_mean_q8_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(negedge clk_i) begin
    out_stall_i = calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) means.check_mean(out_mean_q8_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    means.write_reg(idx, data);
    reg_writes++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    in_sample_i = s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    means.note_sample(s);
    sent++;
    calm = (sent >= CALM_FROM && sent < CALM_TO);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (means.pending() != 0) @(negedge clk_i);
    phases++;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 3))
        0: return SAMPLE_MAX;
        1: return SAMPLE_MIN;
        2: return SAMPLE_ZERO;
        default: return SAMPLE_NEG1;
      endcase
    end
    if (r < 30) return SAMPLE_BITS'($signed($urandom_range(0, 8)) - 4);
    return SAMPLE_BITS'($urandom());
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return CFG_DATA_W'($urandom_range(1, 8));
    if (r < 75) return CFG_DATA_W'($urandom_range(9, MAX_WINDOW - 1));
    if (r < 88) return CFG_DATA_W'(MAX_WINDOW);
    if (r < 92) return '0;
    return CFG_DATA_W'($urandom_range(MAX_WINDOW + 1, 127));
  endfunction

  initial begin
    int n_items;
    int r;
    means       = new();
    calm        = 1'b0;
    sent        = 0;
    reg_writes  = 0;
    phases      = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_sample_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: partial fill with extremes
    repeat (3) send_sample(SAMPLE_MAX);
    repeat (3) send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_ZERO);
    send_sample(SAMPLE_NEG1);
    drain();

    // weighted, zero length acts as one
    write_reg(CFG_MEAN_MODE, '1);
    write_reg(CFG_WINDOW_LENGTH, '0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_NEG1);
    drain();

    // length above maximum clamps
    write_reg(CFG_WINDOW_LENGTH, '1);
    repeat (4) send_sample(SAMPLE_MAX);
    drain();

    // unmapped index keeps the window
    write_reg(CFG_IDX_TOP, 7'h55);
    write_reg(CFG_IDX_FREE, '1);
    repeat (2) send_sample(SAMPLE_MIN);
    drain();

    write_reg(CFG_MEAN_MODE, '0);
    write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(MAX_WINDOW + 1));
    repeat (3) send_sample(SAMPLE_MIN);
    drain();

    while (sent < ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 15) write_reg(CFG_IDX_TOP - CFG_IDX_W'($urandom_range(0, 13)),
                            CFG_DATA_W'($urandom()));
      r = $urandom_range(0, 99);
      if (r < 50) begin
        write_reg(CFG_WINDOW_LENGTH, pick_length());
        write_reg(CFG_MEAN_MODE, CFG_DATA_W'($urandom()));
      end else if (r < 65) begin
        write_reg(CFG_MEAN_MODE, CFG_DATA_W'($urandom()));
        write_reg(CFG_WINDOW_LENGTH, pick_length());
      end else if (r < 80) begin
        write_reg(CFG_WINDOW_LENGTH, pick_length());
      end else if (r < 90) begin
        write_reg(CFG_MEAN_MODE, CFG_DATA_W'($urandom()));
      end
      n_items = $urandom_range(1, 3 * means.span() + 8);
      if (n_items > ITEMS - sent) n_items = ITEMS - sent;
      repeat (n_items) send_sample(pick_sample());
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Run covered %0d samples, %0d means checked, over %0d phases", sent,
             means.checked, phases);
    $display("and %0d register writes incl. clamped lengths and unmapped indexes",
             reg_writes);
    if (means.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
